>>> rtl/fir_filter_circular_macros.svh
// Assertion macros for the circular-buffer FIR filter.
// Each use names a label, an antecedent, a consequent and a message.
`ifndef FIR_FILTER_CIRCULAR_MACROS_SVH
`define FIR_FILTER_CIRCULAR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define FIRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define FIRC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FIRC_ASSERT_IMP(lbl, ante, cons, msg)
`define FIRC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/firc_pkg.sv
`timescale 1ns / 1ps

package firc_pkg;

    // Filter length and derived widths
    localparam int TAPS      = 64;
    localparam int IDX_W     = $clog2(TAPS);
    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = 6;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = PROD_W + IDX_W;
    localparam int FRAC_W    = 15;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Command codes carried in tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // One classified item as it travels through the queue
    typedef struct packed {
        logic    is_load;
        logic    tap_ok;
        t_idx    tap;
        t_sample value;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Status of the MAC engine, seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_back_status;

endpackage

>>> rtl/fir_filter_circular.sv
// Sample item: written to the delay line, swept through all taps (RUN, DRAIN), then
// loaded into the output register in DONE; no further item is taken until then, as the
// single shared MAC walks all taps; coefficient loads retire one per cycle while idle.
// Reset (synchronous, active low) clears delay line and coefficient valid bits,
// so both stores read as zero at once; write position returns to 0.
`timescale 1ns / 1ps

`include "fir_filter_circular_macros.svh"

module fir_filter_circular (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: [5:0] tap_index, [21:6] value, [23:22] zero
    input  logic [firc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: [0] command
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: [15:0] filtered
    output logic [firc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: [0] saturated
    output logic [0:0]                     m_axis_tuser
);
    import firc_pkg::*;

    logic                q_valid;
    logic                q_ready;
    t_cmd                q_cmd;
    logic signed [15:0]  filtered;
    logic                saturated;
    t_back_status        back_st;

    // Front: accept and classify items into the queue
    firc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_tdata (s_axis_tdata),
        .i_in_tuser (s_axis_tuser[0]),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_ready  (q_ready)
    );

    // Back: memory updates and the MAC sweep
    firc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_ready   (q_ready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_filtered  (filtered),
        .o_saturated (saturated),
        .o_status    (back_st)
    );

    assign m_axis_tdata    = filtered;
    assign m_axis_tuser[0] = saturated;

    // Checks
    `FIRC_ASSERT_IMP(a_pop_needs_item, q_ready, q_valid, "queue popped while empty")
    `FIRC_ASSERT_IMP(a_full_means_busy, !s_axis_tready, q_valid, "stalled with empty queue")
    `FIRC_ASSERT_IMP(a_no_pop_when_busy, back_st.busy, !q_ready, "item taken mid-sweep")
    `FIRC_ASSERT_NXT(a_done_then_valid, back_st.done && (!m_axis_tvalid || m_axis_tready),
        m_axis_tvalid, "result not loaded after sweep")

endmodule

>>> rtl/firc_front.sv
`timescale 1ns / 1ps

module firc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [firc_pkg::S_TDATA_W-1:0] i_in_tdata,
    input  logic                          i_in_tuser,
    output logic                          o_q_valid,
    output firc_pkg::t_cmd                o_q_cmd,
    input  logic                          i_q_ready
);
    import firc_pkg::*;

    t_cmd             r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             w_push;
    logic             w_pop;
    logic [TAP_W-1:0] w_tap_raw;
    t_cmd             w_cmd;

    // Classify the incoming item
    assign w_tap_raw     = i_in_tdata[TAP_W-1:0];
    assign w_cmd.is_load = (i_in_tuser == CMD_LOAD);
    assign w_cmd.tap_ok  = (int'(w_tap_raw) < TAPS);
    assign w_cmd.tap     = IDX_W'(w_tap_raw);
    assign w_cmd.value   = i_in_tdata[TAP_W +: SAMPLE_W];

    // Two-entry queue toward the MAC engine
    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_cmd    = r_q[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_comb begin
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr_ptr] <= w_cmd;
    end

endmodule

>>> rtl/firc_back.sv
`timescale 1ns / 1ps

module firc_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  firc_pkg::t_cmd          i_q_cmd,
    output logic                    o_q_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [15:0]      o_filtered,
    output logic                    o_saturated,
    output firc_pkg::t_back_status  o_status
);
    import firc_pkg::*;

    // Sample and coefficient memories with per-entry valid bits
    t_sample            r_delay_mem [TAPS];
    t_sample            r_coef_mem  [TAPS];
    logic [TAPS-1:0]    r_delay_vld;
    logic [TAPS-1:0]    r_coef_vld;

    t_state             r_state;
    t_state             n_state;
    t_idx               r_wr_pos;
    t_idx               r_rd_pos;
    t_idx               r_cnt;

    // MAC pipeline
    t_sample            r_x_rd;
    t_sample            r_c_rd;
    logic               r_x_ok;
    logic               r_c_ok;
    logic               r_p1;
    logic signed [PROD_W-1:0] r_prod;
    logic               r_p2;
    logic signed [ACC_W-1:0]  r_acc;

    logic               r_out_valid;
    t_sample            r_filtered;
    logic               r_saturated;

    // FSM outputs
    logic               w_pop;
    logic               w_coef_we;
    logic               w_delay_we;
    logic               w_issue;
    logic               w_acc_clr;
    logic               w_out_load;
    logic               w_last;

    // Rounding and saturation
    logic signed [ACC_W-1:0]  w_sum;
    logic [ACC_W-31:0]        w_top;
    logic                     w_fits;
    t_sample                  w_y;

    assign w_last = (r_cnt == IDX_W'(TAPS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && !i_q_cmd.is_load) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_p1 && !r_p2) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_pop      = 1'b0;
        w_coef_we  = 1'b0;
        w_delay_we = 1'b0;
        w_issue    = 1'b0;
        w_acc_clr  = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_pop = i_q_valid;
                if (i_q_valid) begin
                    w_coef_we  = i_q_cmd.is_load && i_q_cmd.tap_ok;
                    w_delay_we = !i_q_cmd.is_load;
                    w_acc_clr  = !i_q_cmd.is_load;
                end
            end
            ST_RUN:   w_issue = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  w_out_load = !r_out_valid || i_out_ready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_cnt       <= '0;
            r_delay_vld <= '0;
            r_coef_vld  <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1    <= w_issue;
            r_p2    <= r_p1;
            if (w_coef_we)  r_coef_vld[i_q_cmd.tap] <= 1'b1;
            if (w_delay_we) begin
                r_delay_vld[r_wr_pos] <= 1'b1;
                r_wr_pos <= (r_wr_pos == IDX_W'(TAPS - 1)) ? '0 : r_wr_pos + 1'b1;
                r_rd_pos <= r_wr_pos;
                r_cnt    <= '0;
            end
            // Walk taps forward and samples backward in time
            if (w_issue) begin
                r_cnt    <= r_cnt + 1'b1;
                r_rd_pos <= (r_rd_pos == '0) ? IDX_W'(TAPS - 1) : r_rd_pos - 1'b1;
            end
            if (w_out_load)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (w_coef_we)  r_coef_mem[i_q_cmd.tap] <= i_q_cmd.value;
        if (w_delay_we) r_delay_mem[r_wr_pos]   <= i_q_cmd.value;
    end

    // Registered memory reads, then multiply, then accumulate
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_x_rd <= r_delay_mem[r_rd_pos];
            r_c_rd <= r_coef_mem[r_cnt];
            r_x_ok <= r_delay_vld[r_rd_pos];
            r_c_ok <= r_coef_vld[r_cnt];
        end
        if (r_p1) begin
            r_prod <= (r_x_ok ? r_x_rd : t_sample'(0)) * (r_c_ok ? r_c_rd : t_sample'(0));
        end
        if (w_acc_clr) begin
            r_acc <= '0;
        end else if (r_p2) begin
            r_acc <= r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // Round half up, shift by 15, clip to 16 bits
    assign w_sum  = r_acc + ACC_W'(1 << (FRAC_W - 1));
    assign w_top  = w_sum[ACC_W-1:30];
    assign w_fits = (&w_top) || !(|w_top);
    assign w_y    = w_fits ? w_sum[30:15]
                  : (w_sum[ACC_W-1] ? 16'sh8000 : 16'sh7FFF);

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_filtered  <= w_y;
            r_saturated <= !w_fits;
        end
    end

    assign o_q_ready       = w_pop;
    assign o_out_valid     = r_out_valid;
    assign o_filtered      = r_filtered;
    assign o_saturated     = r_saturated;
    assign o_status.busy   = (r_state != ST_IDLE);
    assign o_status.done   = (r_state == ST_DONE);

endmodule

>>> tb/fir_filter_circular_monitor.sv
`timescale 1ns / 1ps

module fir_filter_circular_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream as seen on the block's slave port
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // tdata: [5:0] tap_index, [21:6] value, [23:22] zero
    input  logic [firc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: [0] command
    input  logic [0:0]                     i_s_tuser,
    // output stream as seen on the block's master port
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: [15:0] filtered
    input  logic [firc_pkg::M_TDATA_W-1:0] i_m_tdata,
    // tuser: [0] saturated
    input  logic [0:0]                     i_m_tuser,
    output int                             o_errors,
    output int                             o_pending
);

    import firc_pkg::*;

    typedef struct packed {
        t_sample filtered;
        logic    saturated;
    } t_fir_out;

    // Shadow copy of the filter state
    t_sample  coef_shadow [TAPS];
    t_sample  history     [TAPS];
    t_idx     wr_pos;
    t_fir_out expected_outputs [$];
    int       err_count;

    // Convolution over the shadow state, rounded half up and clipped
    function automatic t_fir_out fir_output();
        longint   acc;
        longint   y;
        t_idx     pos;
        t_fir_out r;
        acc = 0;
        pos = wr_pos;
        for (int i = 0; i < TAPS; i++) begin
            pos = pos - 1'b1;
            acc += longint'(coef_shadow[i]) * longint'(history[pos]);
        end
        y = (acc + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
        r.saturated = 1'b0;
        if (y > 32767) begin
            y = 32767;
            r.saturated = 1'b1;
        end else if (y < -32768) begin
            y = -32768;
            r.saturated = 1'b1;
        end
        r.filtered = y[SAMPLE_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fir_out exp_out;
        t_idx     tap;
        t_sample  val;
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                coef_shadow[i] = '0;
                history[i]     = '0;
            end
            wr_pos = '0;
            expected_outputs.delete();
            err_count = 0;
        end else begin
            // Output side first, so a result never meets an item taken this edge
            if (i_m_tvalid && i_m_tready) begin
                if (expected_outputs.size() == 0) begin
                    $error("unexpected output item: filtered=%0d saturated=%0d",
                           $signed(i_m_tdata), i_m_tuser[0]);
                    err_count++;
                end else begin
                    exp_out = expected_outputs.pop_front();
                    if (i_m_tdata !== exp_out.filtered) begin
                        $error("filtered: expected %0d, got %0d",
                               exp_out.filtered, $signed(i_m_tdata));
                        err_count++;
                    end
                    if (i_m_tuser[0] !== exp_out.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               exp_out.saturated, i_m_tuser[0]);
                        err_count++;
                    end
                end
            end
            // Input side: update shadow state, queue the expected output
            if (i_s_tvalid && i_s_tready) begin
                tap = i_s_tdata[TAP_W-1:0];
                val = i_s_tdata[TAP_W+SAMPLE_W-1:TAP_W];
                if (i_s_tuser[0] == CMD_LOAD) begin
                    coef_shadow[tap] = val;
                end else begin
                    history[wr_pos] = val;
                    wr_pos = wr_pos + 1'b1;
                    expected_outputs.push_back(fir_output());
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_outputs.size();
    end

endmodule

>>> tb/tb_fir_filter_circular.sv
`timescale 1ns / 1ps

module tb_fir_filter_circular;

    import firc_pkg::*;

    localparam int LATENCY     = TAPS + 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 3000;
    localparam int BURST_ITEMS = 110;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_req;
    bit   hold_taken;
    int   hold_left;
    int   cycle_count;
    int   errors;
    int   pending;

    fir_filter_circular uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fir_filter_circular_monitor monitor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Output-side backpressure, with one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        hold_taken = 1'b0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one item after random idle cycles, return once it is taken
    task automatic push_item(input logic cmd, input t_idx tap, input t_sample val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(S_TDATA_W - TAP_W - SAMPLE_W){1'b0}}, val, tap};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Random mix: mostly samples, some coefficient loads kept small so
    // that sums often stay in range
    task automatic random_burst(input int count);
        int      pick;
        int      r;
        t_sample v;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            r    = $urandom_range(99);
            if (r < 5) begin
                v = 16'sh7FFF;
            end else if (r < 10) begin
                v = 16'sh8000;
            end else if (pick < 25 && r < 70) begin
                v = t_sample'($urandom_range(2047) - 1024);
            end else begin
                v = t_sample'($urandom_range(65535));
            end
            if (pick < 25) begin
                push_item(CMD_LOAD, t_idx'($urandom_range(TAPS - 1)), v);
            end else begin
                push_item(CMD_SAMPLE, t_idx'($urandom_range(63)), v);
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= '0;
        hold_req       <= 1'b0;
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero taps, extremes, clipping both ways, rounding
        push_item(CMD_SAMPLE, 6'd0, 16'sh7FFF);
        push_item(CMD_LOAD, 6'd0, 16'sh7FFF);
        push_item(CMD_LOAD, 6'd63, 16'sh8000);
        push_item(CMD_SAMPLE, 6'd63, 16'sh7FFF);
        push_item(CMD_SAMPLE, 6'd0, 16'sh8000);
        push_item(CMD_SAMPLE, 6'd0, 16'shFFFF);
        push_item(CMD_SAMPLE, 6'd0, 16'sh0000);
        push_item(CMD_LOAD, 6'd1, 16'sh7FFF);
        push_item(CMD_SAMPLE, 6'd0, 16'sh7FFF);
        push_item(CMD_SAMPLE, 6'd0, 16'sh7FFF);
        push_item(CMD_LOAD, 6'd0, 16'sh8000);
        push_item(CMD_LOAD, 6'd1, 16'sh8000);
        push_item(CMD_SAMPLE, 6'd0, 16'sh7FFF);
        push_item(CMD_SAMPLE, 6'd0, 16'sh7FFF);
        push_item(CMD_SAMPLE, 6'd0, 16'sh8000);
        push_item(CMD_SAMPLE, 6'd0, 16'sh8000);
        push_item(CMD_LOAD, 6'd0, 16'sh0001);
        push_item(CMD_LOAD, 6'd1, 16'sh0000);
        push_item(CMD_LOAD, 6'd63, 16'sh0000);
        push_item(CMD_SAMPLE, 6'd0, 16'sh4000);
        push_item(CMD_SAMPLE, 6'd0, 16'shC000);
        push_item(CMD_SAMPLE, 6'd0, 16'sh0000);

        // Random phases with different idle patterns
        random_burst(BURST_ITEMS);
        send_idle_pct <= 69;
        random_burst(BURST_ITEMS);
        send_idle_pct  <= 0;
        recv_stall_pct <= 69;
        random_burst(BURST_ITEMS);
        send_idle_pct  <= 12;
        recv_stall_pct <= 12;
        random_burst(BURST_ITEMS);

        // Long output hold while the sender keeps pushing
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        hold_req       <= 1'b1;
        random_burst(BURST_ITEMS);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
